>>> rtl/core/audio_block_timestamp_projector_macros.svh
// assertion helpers used by the top-level rtl module
`ifndef AUDIO_BLOCK_TIMESTAMP_PROJECTOR_MACROS_SVH
`define AUDIO_BLOCK_TIMESTAMP_PROJECTOR_MACROS_SVH

// same-cycle implication
`define ABTP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ABTP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/abtp_pkg.sv
package abtp_pkg;

   localparam int DIV_W       = 96;
   localparam int DIV_STEPS   = 96;
   localparam int DIV_CNT_W   = 7;
   localparam int CSR_ADDR_W  = 6;
   localparam int MUL_A_W     = 32;
   localparam int MUL_P_W     = 62;

   localparam logic [29:0] NS_PER_S = 30'd1000000000;

   localparam logic [19:0] SAMPLE_RATE_RST    = 20'd48000;
   localparam logic [39:0] MAX_SAMPLE_AGE_RST = 40'd500000000;
   localparam logic [39:0] MAX_ANCHOR_AGE_RST = 40'd5000000000;
   localparam logic [39:0] MAX_BEHIND_RST     = 40'd2000000000;
   localparam logic [39:0] MAX_AHEAD_RST      = 40'd50000000;

   typedef enum logic [1:0] {
      FUNC_PUBLISH = 2'd0,
      FUNC_PROJECT = 2'd1,
      FUNC_CLEAR   = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      REG_SAMPLE_RATE    = 3'd0,
      REG_MAX_SAMPLE_AGE = 3'd1,
      REG_MAX_ANCHOR_AGE = 3'd2,
      REG_MAX_BEHIND     = 3'd3,
      REG_MAX_AHEAD      = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIV_P_START,
      ST_DIV_P,
      ST_CHECK,
      ST_WINDOW,
      ST_FB_MUL,
      ST_FB_START,
      ST_DIV_F,
      ST_FB_FIN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [63:0] frame_position;
      logic signed [63:0] frame_time_ns;
      logic [63:0]        sampled_at_ns;
      logic signed [63:0] block_start_frame;
      logic [15:0]        block_frames;
      logic [63:0]        callback_entry_ns;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [63:0] timestamp_ns;
      logic        from_anchor;
   } rsp_type;

   typedef struct packed {
      logic [19:0] sample_rate;
      logic [39:0] max_sample_age;
      logic [39:0] max_anchor_age;
      logic [39:0] max_behind;
      logic [39:0] max_ahead;
   } cfg_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic             rem_nz;
   } div_rsp_type;

endpackage

>>> rtl/core/abtp_csr.sv
module abtp_csr
   import abtp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [63:0]           pwdata,
   output logic [63:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx    = reg_index_type'(paddr[CSR_ADDR_W-1:3]);
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_SAMPLE_RATE:    cfg_in.sample_rate    = pwdata[19:0];
            REG_MAX_SAMPLE_AGE: cfg_in.max_sample_age = pwdata[39:0];
            REG_MAX_ANCHOR_AGE: cfg_in.max_anchor_age = pwdata[39:0];
            REG_MAX_BEHIND:     cfg_in.max_behind     = pwdata[39:0];
            REG_MAX_AHEAD:      cfg_in.max_ahead      = pwdata[39:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SAMPLE_RATE:    prdata = {44'd0, cfg_ff.sample_rate};
         REG_MAX_SAMPLE_AGE: prdata = {24'd0, cfg_ff.max_sample_age};
         REG_MAX_ANCHOR_AGE: prdata = {24'd0, cfg_ff.max_anchor_age};
         REG_MAX_BEHIND:     prdata = {24'd0, cfg_ff.max_behind};
         REG_MAX_AHEAD:      prdata = {24'd0, cfg_ff.max_ahead};
         default:            prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_rate    <= SAMPLE_RATE_RST;
         cfg_ff.max_sample_age <= MAX_SAMPLE_AGE_RST;
         cfg_ff.max_anchor_age <= MAX_ANCHOR_AGE_RST;
         cfg_ff.max_behind     <= MAX_BEHIND_RST;
         cfg_ff.max_ahead      <= MAX_AHEAD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/abtp_div.sv
module abtp_div
   import abtp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] numer,
   input  logic [19:0]      divisor,
   output div_rsp_type      rsp
);

   logic [DIV_W-1:0]     num_ff, num_in;
   logic [19:0]          rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [20:0]          trial;
   logic [20:0]          diff;
   logic                 ge;

   assign trial = {rem_ff, num_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign ge    = trial >= {1'b0, divisor};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         rem_in  = 20'd0;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_W-2:0], ge};
         rem_in = ge ? diff[19:0] : trial[19:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff;
   assign rsp.rem_nz   = |rem_ff;

endmodule

>>> rtl/core/audio_block_timestamp_projector.sv
// Keeps one timing anchor and answers each transaction with exactly one result.
// A publish, a clear, or a projection that falls straight to a zero fallback
// passes from decode directly to the result state. A projection multiplies the
// frame distance by 1e9 in two 32-bit halves on one shared multiplier and
// divides by the sample rate in a bit-serial restoring divider of 96 steps. A
// fallback to entry time minus block duration takes a pass of the same
// multiplier and divider, both when the anchor checks fail up front and when
// the projected value is rejected after its division. A stalled rsp side holds
// the block in its result state. One transaction is worked on at a time;
// req_ready is high in idle even while a result waits on the rsp side.
module audio_block_timestamp_projector
   import abtp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [63:0]           pwdata,
   output logic [63:0]           prdata,
   output logic                  pready
);

`include "audio_block_timestamp_projector_macros.svh"

   cfg_type     cfg;
   div_rsp_type div_rsp;

   state_type   state_ff, state_in;
   req_type     req_ff;
   logic [63:0] anchor_frame_ff, anchor_frame_in;
   logic [63:0] anchor_time_ff, anchor_time_in;
   logic [63:0] anchor_sampled_ff, anchor_sampled_in;
   logic        neg_ff, neg_in;
   logic [63:0] mag_ff, mag_in;
   logic [MUL_P_W-1:0] prod_lo_ff, prod_lo_in;
   logic [MUL_P_W-1:0] prod_hi_ff, prod_hi_in;
   logic [63:0] result_ff, result_in;
   logic        proj_ok_ff, proj_ok_in;
   rsp_type     res_data_ff, res_data_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [63:0] fp, ft, sa, bsf, entry;
   logic        pub_ok, pre_ok, fb_zero, win_ok;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_P_W-1:0] mul_p;
   logic        div_start;
   logic [DIV_W-1:0] div_numer;
   logic [64:0] sum65;
   logic [63:0] qlo;
   logic        q_hi_nz;
   logic [63:0] dur;

   abtp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   abtp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .numer   (div_numer),
      .divisor (cfg.sample_rate),
      .rsp     (div_rsp)
   );

   assign fp    = req_ff.frame_position;
   assign ft    = req_ff.frame_time_ns;
   assign sa    = req_ff.sampled_at_ns;
   assign bsf   = req_ff.block_start_frame;
   assign entry = req_ff.callback_entry_ns;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // shared multiplier
   always_comb begin
      case (state_ff)
         ST_MUL_LO: mul_a = mag_ff[31:0];
         ST_MUL_HI: mul_a = mag_ff[63:32];
         ST_FB_MUL: mul_a = {16'd0, req_ff.block_frames};
         default:   mul_a = '0;
      endcase
   end
   assign mul_p = {{(MUL_P_W-MUL_A_W){1'b0}}, mul_a} * {{(MUL_P_W-30){1'b0}}, NS_PER_S};

   assign div_start = (state_ff == ST_DIV_P_START) || (state_ff == ST_FB_START);
   assign div_numer = (state_ff == ST_FB_START) ? {34'd0, prod_lo_ff}
                    : ({34'd0, prod_lo_ff} + {2'd0, prod_hi_ff, 32'd0});

   assign pub_ok = !fp[63] && (ft != 64'd0) && !ft[63] && (sa != 64'd0)
                && !((ft > sa) && ((ft - sa) > {24'd0, cfg.max_ahead}))
                && !((sa > ft) && ((sa - ft) > {24'd0, cfg.max_anchor_age}));

   assign pre_ok = !bsf[63] && (cfg.sample_rate != 20'd0) && (entry != 64'd0)
                && (anchor_time_ff != 64'd0) && !anchor_time_ff[63]
                && (anchor_sampled_ff != 64'd0) && !(anchor_sampled_ff > entry)
                && !((entry - anchor_sampled_ff) > {24'd0, cfg.max_sample_age});

   assign fb_zero = (entry == 64'd0) || (req_ff.block_frames == 16'd0)
                 || (cfg.sample_rate == 20'd0);

   assign q_hi_nz = |div_rsp.quotient[DIV_W-1:64];
   assign qlo     = div_rsp.quotient[63:0];
   assign sum65   = {1'b0, anchor_time_ff} + {1'b0, qlo};
   assign dur     = div_rsp.quotient[63:0];

   assign win_ok = proj_ok_ff
                && !((result_ff > entry) && ((result_ff - entry) > {24'd0, cfg.max_ahead}))
                && !((entry > result_ff) && ((entry - result_ff) > {24'd0, cfg.max_behind}));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:        if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            if (func_type'(req_ff.func) == FUNC_PROJECT) begin
               if (pre_ok)       state_in = ST_MUL_LO;
               else if (fb_zero) state_in = ST_RESULT;
               else              state_in = ST_FB_MUL;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_MUL_LO:      state_in = ST_MUL_HI;
         ST_MUL_HI:      state_in = ST_DIV_P_START;
         ST_DIV_P_START: state_in = ST_DIV_P;
         ST_DIV_P:       if (div_rsp.done) state_in = ST_CHECK;
         ST_CHECK:       state_in = ST_WINDOW;
         ST_WINDOW: begin
            if (win_ok)       state_in = ST_RESULT;
            else if (fb_zero) state_in = ST_RESULT;
            else              state_in = ST_FB_MUL;
         end
         ST_FB_MUL:      state_in = ST_FB_START;
         ST_FB_START:    state_in = ST_DIV_F;
         ST_DIV_F:       if (div_rsp.done) state_in = ST_FB_FIN;
         ST_FB_FIN:      state_in = ST_RESULT;
         ST_RESULT:      if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      anchor_frame_in   = anchor_frame_ff;
      anchor_time_in    = anchor_time_ff;
      anchor_sampled_in = anchor_sampled_ff;
      neg_in            = neg_ff;
      mag_in            = mag_ff;
      prod_lo_in        = prod_lo_ff;
      prod_hi_in        = prod_hi_ff;
      result_in         = result_ff;
      proj_ok_in        = proj_ok_ff;
      res_data_in       = res_data_ff;
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_DECODE: begin
            res_data_in = '0;
            neg_in      = bsf < anchor_frame_ff;
            mag_in      = (bsf < anchor_frame_ff) ? (anchor_frame_ff - bsf)
                                                  : (bsf - anchor_frame_ff);
            case (func_type'(req_ff.func))
               FUNC_PUBLISH: begin
                  res_data_in.accepted = pub_ok;
                  if (pub_ok) begin
                     anchor_frame_in   = fp;
                     anchor_time_in    = ft;
                     anchor_sampled_in = sa;
                  end
               end
               FUNC_CLEAR: begin
                  anchor_frame_in   = 64'd0;
                  anchor_time_in    = 64'd0;
                  anchor_sampled_in = 64'd0;
               end
               default: res_data_in = '0;
            endcase
         end
         ST_MUL_LO: prod_lo_in = mul_p;
         ST_MUL_HI: prod_hi_in = mul_p;
         ST_FB_MUL: prod_lo_in = mul_p;
         ST_CHECK: begin
            if (!neg_ff) begin
               result_in  = sum65[63:0];
               proj_ok_in = !q_hi_nz && !sum65[64]
                         && !((sum65[63:0] == {64{1'b1}}) && div_rsp.rem_nz);
            end else begin
               result_in  = anchor_time_ff - qlo - {63'd0, div_rsp.rem_nz};
               proj_ok_in = !q_hi_nz && (qlo < anchor_time_ff);
            end
         end
         ST_WINDOW: begin
            if (win_ok) begin
               res_data_in.timestamp_ns = result_ff;
               res_data_in.from_anchor  = 1'b1;
            end
         end
         ST_FB_FIN: begin
            res_data_in.timestamp_ns = (dur >= entry) ? 64'd1 : (entry - dur);
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_data_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: rsp_in = rsp_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         anchor_frame_ff   <= 64'd0;
         anchor_time_ff    <= 64'd0;
         anchor_sampled_ff <= 64'd0;
      end else begin
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         anchor_frame_ff   <= anchor_frame_in;
         anchor_time_ff    <= anchor_time_in;
         anchor_sampled_ff <= anchor_sampled_in;
      end
      if (req_valid && req_ready) req_ff <= req_data;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      prod_lo_ff  <= prod_lo_in;
      prod_hi_ff  <= prod_hi_in;
      result_ff   <= result_in;
      proj_ok_ff  <= proj_ok_in;
      res_data_ff <= res_data_in;
      rsp_ff      <= rsp_in;
   end

   `ABTP_ASSERT_NOW(a_div_done_wait, div_rsp.done, state_ff == ST_DIV_P || state_ff == ST_DIV_F, "divider done outside a wait state")
   `ABTP_ASSERT_NEXT(a_accept_decode, req_valid && req_ready, state_ff == ST_DECODE, "accepted transaction not decoded")
   `ABTP_ASSERT_NOW(a_rsp_kind, rsp_valid && rsp_data.from_anchor, !rsp_data.accepted, "projection result flagged as publish")
   `ABTP_ASSERT_NEXT(a_clear_anchor, state_ff == ST_DECODE && req_ff.func == FUNC_CLEAR, anchor_time_ff == 64'd0 && anchor_sampled_ff == 64'd0, "clear left an anchor")

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import abtp_pkg::*;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int SETTLE_CYCLES = 240;
   localparam logic [63:0] NS = 64'd1000000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic pready;

   audio_block_timestamp_projector DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // model copy of configuration and anchor
   logic [19:0] m_rate;
   logic [39:0] m_sample_age, m_anchor_age, m_behind, m_ahead;
   logic [63:0] m_frame, m_time, m_sampled;

   rsp_type expected_rsp[$];
   int errors = 0;
   int cycles = 0;
   bit idle_en = 1'b1;
   int hold_left = 0;
   int stall_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready = 1'b0;
      end else if (idle_en && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // result check
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t unexpected transaction %h", $time, rsp_data);
         end else begin
            exp_r = expected_rsp.pop_front();
            if (exp_r.accepted !== rsp_data.accepted) begin
               errors++;
               $display("%0t accepted exp %b act %b", $time, exp_r.accepted,
                        rsp_data.accepted);
            end
            if (exp_r.timestamp_ns !== rsp_data.timestamp_ns) begin
               errors++;
               $display("%0t timestamp_ns exp %0d act %0d", $time, exp_r.timestamp_ns,
                        rsp_data.timestamp_ns);
            end
            if (exp_r.from_anchor !== rsp_data.from_anchor) begin
               errors++;
               $display("%0t from_anchor exp %b act %b", $time, exp_r.from_anchor,
                        rsp_data.from_anchor);
            end
         end
      end
   end

   function automatic logic [63:0] block_duration_fallback(logic [63:0] entry,
                                                            logic [15:0] frames);
      logic [63:0] dur;
      if (entry == 0 || frames == 0 || m_rate == 0) return 64'd0;
      dur = (64'(frames) * NS) / 64'(m_rate);
      if (dur >= entry) return 64'd1;
      return entry - dur;
   endfunction

   function automatic bit try_publish(logic [63:0] fp, logic [63:0] ft, logic [63:0] sa);
      if (fp[63] || ft == 0 || ft[63] || sa == 0) return 1'b0;
      if (ft > sa && ft - sa > 64'(m_ahead)) return 1'b0;
      if (sa > ft && sa - ft > 64'(m_anchor_age)) return 1'b0;
      m_frame = fp;
      m_time = ft;
      m_sampled = sa;
      return 1'b1;
   endfunction

   function automatic bit try_project(logic [63:0] bsf, logic [63:0] entry,
                                      output logic [63:0] ts);
      logic [63:0] mag;
      logic [127:0] num, quo, rem;
      logic [64:0] sum;
      logic [63:0] res;
      bit neg;
      ts = 64'd0;
      if (bsf[63] || m_rate == 0 || entry == 0) return 1'b0;
      if (m_time == 0 || m_time[63] || m_sampled == 0) return 1'b0;
      if (m_sampled > entry || entry - m_sampled > 64'(m_sample_age)) return 1'b0;
      neg = bsf < m_frame;
      mag = neg ? m_frame - bsf : bsf - m_frame;
      num = 128'(mag) * 128'(NS);
      quo = num / 128'(m_rate);
      rem = num % 128'(m_rate);
      if (quo[127:64] != 0) return 1'b0;
      if (!neg) begin
         sum = 65'(m_time) + 65'(quo[63:0]);
         if (sum[64]) return 1'b0;
         res = sum[63:0];
         if (res == '1 && rem != 0) return 1'b0;
      end else begin
         if (quo[63:0] >= m_time) return 1'b0;
         res = m_time - quo[63:0] - (rem != 0 ? 64'd1 : 64'd0);
      end
      if (res > entry && res - entry > 64'(m_ahead)) return 1'b0;
      if (entry > res && entry - res > 64'(m_behind)) return 1'b0;
      ts = res;
      return 1'b1;
   endfunction

   function automatic rsp_type predict_timestamp(req_type r);
      rsp_type o;
      logic [63:0] ts;
      o = '0;
      case (func_type'(r.func))
         FUNC_PUBLISH: o.accepted = try_publish(r.frame_position, r.frame_time_ns,
                                                r.sampled_at_ns);
         FUNC_PROJECT: begin
            if (try_project(r.block_start_frame, r.callback_entry_ns, ts)) begin
               o.timestamp_ns = ts;
               o.from_anchor = 1'b1;
            end else begin
               o.timestamp_ns = block_duration_fallback(r.callback_entry_ns,
                                                        r.block_frames);
            end
         end
         FUNC_CLEAR: begin
            m_frame = '0;
            m_time = '0;
            m_sampled = '0;
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic send_item(req_type r);
      if (idle_en && $urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 10)) @(negedge clock);
      req_data = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_rsp.push_back(predict_timestamp(r));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [63:0] value);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = CSR_ADDR_W'(8 * int'(idx));
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      case (idx)
         REG_SAMPLE_RATE: m_rate = value[19:0];
         REG_MAX_SAMPLE_AGE: m_sample_age = value[39:0];
         REG_MAX_ANCHOR_AGE: m_anchor_age = value[39:0];
         REG_MAX_BEHIND: m_behind = value[39:0];
         default: m_ahead = value[39:0];
      endcase
   endtask

   task automatic set_config(logic [19:0] rate, logic [39:0] sage, logic [39:0] aage,
                             logic [39:0] behind, logic [39:0] ahead);
      wait_drained();
      write_reg(REG_SAMPLE_RATE, 64'(rate));
      write_reg(REG_MAX_SAMPLE_AGE, 64'(sage));
      write_reg(REG_MAX_ANCHOR_AGE, 64'(aage));
      write_reg(REG_MAX_BEHIND, 64'(behind));
      write_reg(REG_MAX_AHEAD, 64'(ahead));
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type mk(func_type f, logic [63:0] a, logic [63:0] b,
                                  logic [63:0] c, logic [63:0] d, logic [15:0] e,
                                  logic [63:0] g);
      req_type r;
      r.func = f;
      r.frame_position = a;
      r.frame_time_ns = b;
      r.sampled_at_ns = c;
      r.block_start_frame = d;
      r.block_frames = e;
      r.callback_entry_ns = g;
      return r;
   endfunction

   function automatic req_type good_publish();
      logic [63:0] sa, ft, fp;
      sa = (rand64() & 64'h0fff_ffff_ffff_ffff) + 64'd1;
      ft = sa - 64'($urandom_range(0, 1000000000)) + 64'($urandom_range(0, 40000000));
      fp = $urandom_range(0, 1) ? (rand64() & 64'h7fff_ffff_ffff_ffff) : 64'($urandom);
      return mk(FUNC_PUBLISH, fp, ft, sa, rand64(), 16'($urandom), rand64());
   endfunction

   function automatic req_type good_project();
      logic [63:0] dfr, span, t, entry, bsf;
      bit neg;
      dfr = 64'($urandom_range(0, (m_rate == 0) ? 1000 : int'(m_rate) / 2));
      neg = $urandom_range(0, 1);
      span = (m_rate == 0) ? 64'd0 : (dfr * NS) / 64'(m_rate);
      t = neg ? m_time - span : m_time + span;
      entry = t - 64'($urandom_range(0, 120000000)) + 64'($urandom_range(0, 70000000));
      bsf = neg ? m_frame - dfr : m_frame + dfr;
      return mk(FUNC_PROJECT, rand64(), rand64(), rand64(), bsf,
                ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom), entry);
   endfunction

   function automatic req_type random_item();
      int k;
      k = $urandom_range(0, 99);
      if (k < 25) return good_publish();
      if (k < 75) return good_project();
      if (k < 78) return mk(FUNC_CLEAR, rand64(), rand64(), rand64(), rand64(),
                            16'($urandom), rand64());
      return mk(func_type'($urandom_range(0, 3)), rand64(), rand64(), rand64(), rand64(),
                16'($urandom), rand64());
   endfunction

   task automatic test_directed();
      logic [63:0] big;
      big = 64'h7fff_ffff_ffff_ffff;
      // project with no anchor, then fallback corners
      send_item(mk(FUNC_PROJECT, '0, '0, '0, 64'd100, 16'd480, 64'd5000000000));
      send_item(mk(FUNC_PROJECT, '0, '0, '0, 64'd100, 16'd480, 64'd0));
      send_item(mk(FUNC_PROJECT, '0, '0, '0, 64'd100, 16'd0, 64'd77));
      send_item(mk(FUNC_PROJECT, '0, '0, '0, 64'd100, 16'hffff, 64'd5));
      // rejected publishes
      send_item(mk(FUNC_PUBLISH, 64'hffff_ffff_ffff_ffff, 64'd1000, 64'd1000, '0, '0, '0));
      send_item(mk(FUNC_PUBLISH, 64'd10, 64'd0, 64'd1000, '0, '0, '0));
      send_item(mk(FUNC_PUBLISH, 64'd10, 64'h8000_0000_0000_0000, 64'd1000, '0, '0, '0));
      send_item(mk(FUNC_PUBLISH, 64'd10, 64'd1000, 64'd0, '0, '0, '0));
      send_item(mk(FUNC_PUBLISH, 64'd10, 64'd1050000001, 64'd1000000000, '0, '0, '0));
      send_item(mk(FUNC_PUBLISH, 64'd10, 64'd1, 64'd5000000002, '0, '0, '0));
      // good anchor and projections around it
      send_item(mk(FUNC_PUBLISH, 64'd48000, 64'd10000000000, 64'd10000000000, '0, '0, '0));
      send_item(mk(FUNC_PROJECT, '0, '0, '0, 64'd48480, 16'd480, 64'd10010000000));
      send_item(mk(FUNC_PROJECT, '0, '0, '0, 64'd47999, 16'd480, 64'd10000000000));
      send_item(mk(FUNC_PROJECT, '0, '0, '0, 64'd60000, 16'd480, 64'd10100000000));
      send_item(mk(FUNC_PROJECT, '0, '0, '0, 64'd0, 16'd480, 64'd10400000000));
      send_item(mk(FUNC_PROJECT, '0, '0, '0, 64'd48000, 16'd480, 64'd9999999999));
      send_item(mk(FUNC_PROJECT, '0, '0, '0, 64'd48000, 16'd480, 64'd10600000000));
      send_item(mk(FUNC_PROJECT, '0, '0, '0, 64'hffff_ffff_0000_0000, 16'd1,
                   64'd10000000001));
      send_item(mk(FUNC_NONE, big, big, '1, big, 16'hffff, '1));
      // anchor near the top of range, projections against it, then clear
      send_item(mk(FUNC_PUBLISH, 64'd0, big, big, '0, '0, '0));
      send_item(mk(FUNC_PROJECT, '0, '0, '0, big, 16'hffff, '1));
      send_item(mk(FUNC_PROJECT, '0, '0, '0, 64'd0, 16'd1, big));
      send_item(mk(FUNC_CLEAR, '1, '1, '1, '1, 16'hffff, '1));
      send_item(mk(FUNC_PROJECT, '0, '0, '0, 64'd1, 16'd1, big));
   endtask

   task automatic test_config_extremes();
      set_config(20'd768000, 40'hff_ffff_ffff, 40'hff_ffff_ffff, 40'hff_ffff_ffff,
                 40'hff_ffff_ffff);
      repeat (40) send_item(random_item());
      set_config(20'd1, 40'd0, 40'd0, 40'd0, 40'd0);
      send_item(mk(FUNC_PUBLISH, 64'd5, 64'd1000, 64'd1000, '0, '0, '0));
      send_item(mk(FUNC_PROJECT, '0, '0, '0, 64'd5, 16'd1, 64'd1000));
      repeat (30) send_item(random_item());
      set_config(20'd0, 40'd500000000, 40'd5000000000, 40'd2000000000, 40'd50000000);
      repeat (15) send_item(random_item());
      set_config(20'd44100, 40'd800000000, 40'd3000000000, 40'd1500000000, 40'd90000000);
      repeat (60) send_item(random_item());
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_left = 3000;
      repeat (20) send_item(random_item());
   endtask

   task automatic test_drain_pause();
      repeat (10) send_item(random_item());
      while (expected_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
      repeat (10) send_item(random_item());
   endtask

   task automatic test_random();
      set_config(20'($urandom_range(8000, 192000)), 40'd500000000, 40'd5000000000,
                 40'd2000000000, 40'd50000000);
      repeat (300) send_item(random_item());
      set_config(20'd48000, 40'd500000000, 40'd5000000000, 40'd2000000000, 40'd50000000);
      repeat (100) send_item(random_item());
      idle_en = 1'b0;
      repeat (60) send_item(random_item());
   endtask

   initial begin
      m_rate = SAMPLE_RATE_RST;
      m_sample_age = MAX_SAMPLE_AGE_RST;
      m_anchor_age = MAX_ANCHOR_AGE_RST;
      m_behind = MAX_BEHIND_RST;
      m_ahead = MAX_AHEAD_RST;
      m_frame = '0;
      m_time = '0;
      m_sampled = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_config_extremes();
      test_backpressure();
      test_drain_pause();
      test_random();
      wait_drained();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/abtp_pkg.sv
rtl/core/abtp_csr.sv
rtl/core/abtp_div.sv
rtl/core/audio_block_timestamp_projector.sv
bench/tb.sv
